### rtl/core/v3mu_pkg.sv
// shared constants, types and rounding helper for the vector3 math unit
// no dependencies; imported by every module of the unit
`default_nettype none

package v3mu_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAT_W      = 32;
    localparam int CFG_W      = 64;
    localparam int NUM_CFG    = 6;
    localparam int CFG_IDX_W  = 3;

    localparam int OPND_W     = (COMP_WIDTH > MAT_W) ? COMP_WIDTH : MAT_W;
    localparam int PROD_W     = 2 * OPND_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int RAD_W      = 2 * COMP_WIDTH;
    localparam int ROOT_W     = COMP_WIDTH;
    localparam int NUM_W      = COMP_WIDTH + FRAC_BITS;
    localparam int SQRT_STG   = ROOT_W;
    localparam int DIV_STG    = NUM_W;
    localparam int RES_TAP    = 3;
    localparam int LEN_TAP    = 2 + SQRT_STG;
    localparam int SIDE_DEPTH = 2 + SQRT_STG + DIV_STG;

    localparam logic [2:0] OP_DOT   = 3'd0;
    localparam logic [2:0] OP_CROSS = 3'd1;
    localparam logic [2:0] OP_LEN   = 3'd2;
    localparam logic [2:0] OP_NORM  = 3'd3;
    localparam logic [2:0] OP_AFF   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;

    localparam t_comp COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam t_comp COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [OPND_W-1:0] a0;
        logic signed [OPND_W-1:0] b0;
        logic signed [OPND_W-1:0] a1;
        logic signed [OPND_W-1:0] b1;
        logic signed [OPND_W-1:0] a2;
        logic signed [OPND_W-1:0] b2;
        logic                     neg1;
        logic signed [MAT_W-1:0]  bias;
    } t_lane_in;

    typedef struct packed {
        logic  ovf;
        t_comp val;
    } t_sat;

    typedef struct packed {
        logic              vld;
        logic [2:0]        op;
        t_comp [2:0]       a;
        t_comp [2:0]       res;
        logic [2:0]        ovf;
        logic [ROOT_W-1:0] len;
    } t_side;

    // round half up to FRAC_BITS then clamp to the component range
    function automatic t_sat round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]      t;
        logic [SUM_W-COMP_WIDTH:0]    hi;
        t_sat                         r;
        t     = (s + ROUND_HALF) >>> FRAC_BITS;
        hi    = t[SUM_W-1:COMP_WIDTH-1];
        r.ovf = !((&hi) || !(|hi));
        r.val = r.ovf ? (t[SUM_W-1] ? COMP_MIN : COMP_MAX) : t[COMP_WIDTH-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/v3mu_lane.sv
// one multiply-accumulate lane: three products, sum with bias, round and clamp
// depends on v3mu_pkg
`default_nettype none

module v3mu_lane
    import v3mu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire t_lane_in                i_opnd,
    output logic signed [SUM_W-1:0]      o_sum,
    output t_sat                         o_res
);

    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic                     r_neg1;
    logic signed [MAT_W-1:0]  r_bias;
    logic signed [SUM_W-1:0]  r_sum;
    t_sat                     r_res;

    logic signed [SUM_W-1:0]  w_p0;
    logic signed [SUM_W-1:0]  w_p1;
    logic signed [SUM_W-1:0]  w_p2;
    logic signed [SUM_W-1:0]  w_bias;
    logic signed [SUM_W-1:0]  n_sum;

    assign w_p0   = SUM_W'(r_p0);
    assign w_p1   = SUM_W'(r_p1);
    assign w_p2   = SUM_W'(r_p2);
    assign w_bias = SUM_W'(r_bias) <<< FRAC_BITS;
    assign n_sum  = w_p0 + (r_neg1 ? -w_p1 : w_p1) + w_p2 + w_bias;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0   <= i_opnd.a0 * i_opnd.b0;
            r_p1   <= i_opnd.a1 * i_opnd.b1;
            r_p2   <= i_opnd.a2 * i_opnd.b2;
            r_neg1 <= i_opnd.neg1;
            r_bias <= i_opnd.bias;
            r_sum  <= n_sum;
            r_res  <= round_sat(r_sum);
        end
    end

    assign o_sum = r_sum;
    assign o_res = r_res;

endmodule

`default_nettype wire

### rtl/core/v3mu_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on v3mu_pkg
`default_nettype none

module v3mu_isqrt
    import v3mu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int REM_W = ROOT_W + 4;

    logic [REM_W-1:0]  r_rem  [SQRT_STG];
    logic [ROOT_W-1:0] r_root [SQRT_STG];
    logic [RAD_W-1:0]  r_rad  [SQRT_STG];

    for (genvar s = 0; s < SQRT_STG; s++) begin : g_stg
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [RAD_W-1:0]  w_rad_in;
        logic [REM_W-1:0]  w_cat;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign w_cat   = {w_rem_in[REM_W-3:0], w_rad_in[RAD_W-1 -: 2]};
        assign w_trial = REM_W'({w_root_in, 2'b01});
        assign w_ge    = (w_cat >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (w_cat - w_trial) : w_cat;
                r_root[s] <= {w_root_in[ROOT_W-2:0], w_ge};
                r_rad[s]  <= {w_rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STG-1];

endmodule

`default_nettype wire

### rtl/core/v3mu_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on v3mu_pkg
`default_nettype none

module v3mu_div
    import v3mu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [ROOT_W-1:0] i_den,
    output logic [NUM_W-1:0]       o_quo
);

    logic [ROOT_W-1:0] r_rem [DIV_STG];
    logic [NUM_W-1:0]  r_nq  [DIV_STG];
    logic [ROOT_W-1:0] r_den [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        logic [ROOT_W-1:0] w_rem_in;
        logic [NUM_W-1:0]  w_nq_in;
        logic [ROOT_W-1:0] w_den_in;
        logic [ROOT_W:0]   w_cat;
        logic [ROOT_W:0]   w_diff;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_nq_in  = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_nq_in  = r_nq[s-1];
            assign w_den_in = r_den[s-1];
        end

        // numerator shifts out at the top while quotient bits enter at the bottom
        assign w_cat  = {w_rem_in, w_nq_in[NUM_W-1]};
        assign w_ge   = (w_cat >= {1'b0, w_den_in});
        assign w_diff = w_cat - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_diff[ROOT_W-1:0] : w_cat[ROOT_W-1:0];
                r_nq[s]  <= {w_nq_in[NUM_W-2:0], w_ge};
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quo = r_nq[DIV_STG-1];

endmodule

`default_nettype wire

### rtl/core/vector3_math_unit.sv
// vector3 math unit: one result per input transaction, one per cycle while the output is not stalled
// throughput 1 item per cycle unless the output stalls; depth set by the 32-stage square root and 48-stage divider
// the whole pipeline advances together while the output register is free or taken
// reset (synchronous, active low) empties the pipeline and loads the identity matrix
// depends on v3mu_pkg, v3mu_lane, v3mu_isqrt, v3mu_div
`default_nettype none

module vector3_math_unit
    import v3mu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [2:0]           i_op,
    input  wire t_comp                i_ax,
    input  wire t_comp                i_ay,
    input  wire t_comp                i_az,
    input  wire t_comp                i_bx,
    input  wire t_comp                i_by,
    input  wire t_comp                i_bz,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_comp                     o_rx,
    output t_comp                     o_ry,
    output t_comp                     o_rz,
    output logic [1:0]                o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]        r_cfg [NUM_CFG];
    logic signed [MAT_W-1:0] w_m   [3][3];
    logic signed [MAT_W-1:0] w_t   [3];

    logic                    r_s0_vld;
    logic [2:0]              r_s0_op;
    t_comp [2:0]             r_s0_a;
    t_comp [2:0]             r_s0_b;

    logic                    w_en;
    logic                    w_load;

    t_lane_in                w_lane_in [3];
    logic signed [SUM_W-1:0] w_lane_sum [3];
    t_sat                    w_lane_res [3];
    logic [ROOT_W-1:0]       w_len;
    logic [NUM_W-1:0]        w_num [3];
    logic [NUM_W-1:0]        w_quo [3];

    t_side                   r_side [SIDE_DEPTH];
    t_side                   n_side [SIDE_DEPTH];
    t_side                   w_last;

    logic                    r_out_vld;
    t_comp                   r_rx;
    t_comp                   r_ry;
    t_comp                   r_rz;
    logic [1:0]              r_status;
    t_comp                   n_rx;
    t_comp                   n_ry;
    t_comp                   n_rz;
    logic [1:0]              n_status;

    function automatic t_sat norm_sat(input logic neg, input logic [NUM_W-1:0] q);
        t_sat r;
        if (neg) begin
            r.ovf = (|q[NUM_W-1:COMP_WIDTH]) || (q[COMP_WIDTH-1] && (|q[COMP_WIDTH-2:0]));
            r.val = r.ovf ? COMP_MIN : t_comp'(~q[COMP_WIDTH-1:0] + 1'b1);
        end else begin
            r.ovf = |q[NUM_W-1:COMP_WIDTH-1];
            r.val = r.ovf ? COMP_MAX : t_comp'(q[COMP_WIDTH-1:0]);
        end
        return r;
    endfunction

    // configuration registers, reset to the identity transform
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= CFG_W'(64'h0000_0000_0001_0000);
            r_cfg[1] <= '0;
            r_cfg[2] <= CFG_W'(64'h0001_0000_0000_0000);
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= CFG_W'(64'h0000_0000_0001_0000);
        end else if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NUM_CFG))) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_mat
        assign w_m[r][0] = r_cfg[2*r][MAT_W-1:0];
        assign w_m[r][1] = r_cfg[2*r][2*MAT_W-1:MAT_W];
        assign w_m[r][2] = r_cfg[2*r+1][MAT_W-1:0];
        assign w_t[r]    = r_cfg[2*r+1][2*MAT_W-1:MAT_W];
    end

    // entry register, refills while the rest of the pipe is held if it is empty
    assign w_en    = !r_out_vld || i_ready;
    assign w_load  = w_en || !r_s0_vld;
    assign o_ready = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_load) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s0_op   <= i_op;
            r_s0_a[0] <= i_ax;
            r_s0_a[1] <= i_ay;
            r_s0_a[2] <= i_az;
            r_s0_b[0] <= i_bx;
            r_s0_b[1] <= i_by;
            r_s0_b[2] <= i_bz;
        end
    end

    // operand routing for the three lanes
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_lane_in[l] = '0;
        end
        case (r_s0_op)
            OP_DOT: begin
                w_lane_in[0].a0 = OPND_W'(r_s0_a[0]);
                w_lane_in[0].b0 = OPND_W'(r_s0_b[0]);
                w_lane_in[0].a1 = OPND_W'(r_s0_a[1]);
                w_lane_in[0].b1 = OPND_W'(r_s0_b[1]);
                w_lane_in[0].a2 = OPND_W'(r_s0_a[2]);
                w_lane_in[0].b2 = OPND_W'(r_s0_b[2]);
            end
            OP_CROSS: begin
                w_lane_in[0].a0   = OPND_W'(r_s0_a[1]);
                w_lane_in[0].b0   = OPND_W'(r_s0_b[2]);
                w_lane_in[0].a1   = OPND_W'(r_s0_a[2]);
                w_lane_in[0].b1   = OPND_W'(r_s0_b[1]);
                w_lane_in[0].neg1 = 1'b1;
                w_lane_in[1].a0   = OPND_W'(r_s0_a[2]);
                w_lane_in[1].b0   = OPND_W'(r_s0_b[0]);
                w_lane_in[1].a1   = OPND_W'(r_s0_a[0]);
                w_lane_in[1].b1   = OPND_W'(r_s0_b[2]);
                w_lane_in[1].neg1 = 1'b1;
                w_lane_in[2].a0   = OPND_W'(r_s0_a[0]);
                w_lane_in[2].b0   = OPND_W'(r_s0_b[1]);
                w_lane_in[2].a1   = OPND_W'(r_s0_a[1]);
                w_lane_in[2].b1   = OPND_W'(r_s0_b[0]);
                w_lane_in[2].neg1 = 1'b1;
            end
            OP_LEN, OP_NORM: begin
                w_lane_in[0].a0 = OPND_W'(r_s0_a[0]);
                w_lane_in[0].b0 = OPND_W'(r_s0_a[0]);
                w_lane_in[0].a1 = OPND_W'(r_s0_a[1]);
                w_lane_in[0].b1 = OPND_W'(r_s0_a[1]);
                w_lane_in[0].a2 = OPND_W'(r_s0_a[2]);
                w_lane_in[0].b2 = OPND_W'(r_s0_a[2]);
            end
            OP_AFF: begin
                for (int l = 0; l < 3; l++) begin
                    w_lane_in[l].a0   = OPND_W'(w_m[l][0]);
                    w_lane_in[l].b0   = OPND_W'(r_s0_a[0]);
                    w_lane_in[l].a1   = OPND_W'(w_m[l][1]);
                    w_lane_in[l].b1   = OPND_W'(r_s0_a[1]);
                    w_lane_in[l].a2   = OPND_W'(w_m[l][2]);
                    w_lane_in[l].b2   = OPND_W'(r_s0_a[2]);
                    w_lane_in[l].bias = w_t[l];
                end
            end
            default: begin
                for (int l = 0; l < 3; l++) begin
                    w_lane_in[l] = '0;
                end
            end
        endcase
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        v3mu_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_opnd (w_lane_in[l]),
            .o_sum  (w_lane_sum[l]),
            .o_res  (w_lane_res[l])
        );
    end

    // sum of squares from lane 0 is non-negative and fits the radicand
    v3mu_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (w_lane_sum[0][RAD_W-1:0]),
        .o_root (w_len)
    );

    for (genvar l = 0; l < 3; l++) begin : g_div
        t_comp                 w_a;
        logic [COMP_WIDTH-1:0] w_mag;

        assign w_a    = r_side[LEN_TAP-1].a[l];
        assign w_mag  = w_a[COMP_WIDTH-1] ? (~w_a + 1'b1) : w_a;
        // add half the divisor so the quotient rounds half away from zero
        assign w_num[l] = {w_mag, {FRAC_BITS{1'b0}}} + NUM_W'(w_len >> 1);

        v3mu_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[l]),
            .i_den (w_len),
            .o_quo (w_quo[l])
        );
    end

    // side line carries op, operands and early results alongside the long units
    always_comb begin
        n_side[0].vld = r_s0_vld;
        n_side[0].op  = r_s0_op;
        n_side[0].a   = r_s0_a;
        n_side[0].res = '0;
        n_side[0].ovf = '0;
        n_side[0].len = '0;
        for (int k = 1; k < SIDE_DEPTH; k++) begin
            n_side[k] = r_side[k-1];
        end
        for (int l = 0; l < 3; l++) begin
            n_side[RES_TAP].res[l] = w_lane_res[l].val;
            n_side[RES_TAP].ovf[l] = w_lane_res[l].ovf;
        end
        n_side[LEN_TAP].len = w_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SIDE_DEPTH; k++) begin
                r_side[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            for (int k = 0; k < SIDE_DEPTH; k++) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    assign w_last = r_side[SIDE_DEPTH-1];

    // merge lane, root and quotient results by opcode
    always_comb begin
        t_sat s0;
        t_sat s1;
        t_sat s2;
        s0       = norm_sat(w_last.a[0][COMP_WIDTH-1], w_quo[0]);
        s1       = norm_sat(w_last.a[1][COMP_WIDTH-1], w_quo[1]);
        s2       = norm_sat(w_last.a[2][COMP_WIDTH-1], w_quo[2]);
        n_rx     = '0;
        n_ry     = '0;
        n_rz     = '0;
        n_status = ST_OK;
        case (w_last.op)
            OP_DOT: begin
                n_rx     = w_last.res[0];
                n_status = w_last.ovf[0] ? ST_OVF : ST_OK;
            end
            OP_CROSS, OP_AFF: begin
                n_rx     = w_last.res[0];
                n_ry     = w_last.res[1];
                n_rz     = w_last.res[2];
                n_status = (|w_last.ovf) ? ST_OVF : ST_OK;
            end
            OP_LEN: begin
                if (w_last.len[ROOT_W-1]) begin
                    n_rx     = COMP_MAX;
                    n_status = ST_OVF;
                end else begin
                    n_rx = t_comp'(w_last.len);
                end
            end
            OP_NORM: begin
                if (w_last.len == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    n_rx     = s0.val;
                    n_ry     = s1.val;
                    n_rz     = s2.val;
                    n_status = (s0.ovf || s1.ovf || s2.ovf) ? ST_OVF : ST_OK;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rx     <= n_rx;
            r_ry     <= n_ry;
            r_rz     <= n_rz;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_rx     = r_rx;
    assign o_ry     = r_ry;
    assign o_rz     = r_rz;
    assign o_status = r_status;

endmodule

`default_nettype wire
